>>> design/ggh_pkg.sv
// Package for the go-to-goal heading controller: widths, CORDIC angle table,
// register indexes and pi constants. No dependencies.
`timescale 1ns / 1ps
package ggh_pkg;
    localparam int ANG_MAX = 20;
    localparam int ATAN_STEPS_DEF = 14;
    localparam int CW = 35;          // CORDIC x/y width, covers gain on full-range deltas
    localparam int ZW = 24;          // angle accumulator width, Q.20
    localparam logic signed [ZW-1:0] PI_Q20 = 24'sd3294199;
    localparam logic signed [15:0] PI_Q12 = 16'sd12868;

    typedef enum logic [2:0] {
        REG_GOAL_X = 3'd0, REG_GOAL_Y = 3'd1, REG_WINDOW = 3'd2,
        REG_GAIN = 3'd3, REG_CRUISE = 3'd4, REG_SPIN = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } cordic_t;

    function automatic logic signed [ZW-1:0] atan_q20(input int i);
        case (i)
            0: atan_q20 = 24'sd823550;  1: atan_q20 = 24'sd486170;
            2: atan_q20 = 24'sd256879;  3: atan_q20 = 24'sd130396;
            4: atan_q20 = 24'sd65451;   5: atan_q20 = 24'sd32757;
            6: atan_q20 = 24'sd16383;   7: atan_q20 = 24'sd8192;
            8: atan_q20 = 24'sd4096;    9: atan_q20 = 24'sd2048;
            10: atan_q20 = 24'sd1024;   11: atan_q20 = 24'sd512;
            12: atan_q20 = 24'sd256;    13: atan_q20 = 24'sd128;
            14: atan_q20 = 24'sd64;     15: atan_q20 = 24'sd32;
            16: atan_q20 = 24'sd16;     17: atan_q20 = 24'sd8;
            18: atan_q20 = 24'sd4;      19: atan_q20 = 24'sd2;
            default: atan_q20 = '0;
        endcase
    endfunction
endpackage

>>> design/ggh_cordic_cell.sv
// One vectoring CORDIC micro-rotation cell with an output register.
// Depends on ggh_pkg.
`timescale 1ns / 1ps
module ggh_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic            aclk,
    input  logic            en,
    input  ggh_pkg::cordic_t din,
    output ggh_pkg::cordic_t dout
);
    ggh_pkg::cordic_t next;

    // Rotate toward the x axis by atan(2^-STEP)
    always_comb begin
        next = din;
        if (!din.y[ggh_pkg::CW-1]) begin
            next.x = din.x + (din.y >>> STEP);
            next.y = din.y - (din.x >>> STEP);
            next.z = din.z + ggh_pkg::atan_q20(STEP);
        end else begin
            next.x = din.x - (din.y >>> STEP);
            next.y = din.y + (din.x >>> STEP);
            next.z = din.z - ggh_pkg::atan_q20(STEP);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dout <= next;
        end
    end
endmodule

>>> design/ggh_cordic_chain.sv
// Registered prerotation followed by a row of CORDIC cells, then rounding and clamping to Q3.12.
// Depends on ggh_pkg and ggh_cordic_cell.
`timescale 1ns / 1ps
module ggh_cordic_chain #(
    parameter int ATAN_STEPS = ggh_pkg::ATAN_STEPS_DEF
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [ggh_pkg::CW-1:0] y_in,
    input  logic signed [ggh_pkg::CW-1:0] x_in,
    output logic signed [14:0]            angle
);
    localparam int N = (ATAN_STEPS < ggh_pkg::ANG_MAX) ? ATAN_STEPS : ggh_pkg::ANG_MAX;

    ggh_pkg::cordic_t stage [N+1];
    ggh_pkg::cordic_t pre;
    logic signed [ggh_pkg::ZW-1:0] zr;
    logic signed [ggh_pkg::ZW-9:0] zs;

    // Fold the left half plane onto the right half plane
    always_comb begin
        pre.x = x_in;
        pre.y = y_in;
        pre.z = '0;
        pre.zero = (x_in == '0) && (y_in == '0);
        if (x_in[ggh_pkg::CW-1]) begin
            pre.x = -x_in;
            pre.y = -y_in;
            pre.z = y_in[ggh_pkg::CW-1] ? -ggh_pkg::PI_Q20 : ggh_pkg::PI_Q20;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stage[0] <= pre;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_cell
        ggh_cordic_cell #(.STEP(i)) u_cell (
            .aclk(aclk), .en(en), .din(stage[i]), .dout(stage[i+1])
        );
    end

    // Round half up, clamp to +/- pi; a zero vector gives zero
    always_comb begin
        zr = stage[N].z + ggh_pkg::ZW'(128);
        zs = zr[ggh_pkg::ZW-1:8];
        if (stage[N].zero) begin
            angle = '0;
        end else if (zs > 16'sd12868) begin
            angle = 15'sd12868;
        end else if (zs < -16'sd12868) begin
            angle = -15'sd12868;
        end else begin
            angle = zs[14:0];
        end
    end
endmodule

>>> design/go_to_goal_heading_controller_core.sv
// Top level of the go-to-goal heading controller: configuration registers,
// pose front end, two CORDIC chains and the steering stage. Depends on ggh_pkg and ggh_cordic_chain.
`timescale 1ns / 1ps
// One pose transaction is accepted per cycle unless the output stalls. Front
// end products, prerotation, one register per CORDIC cell, a multiply stage
// and an output register form a pipeline that advances whenever the output is
// empty or being taken, so a stalled output holds the whole pipeline.
module go_to_goal_heading_controller_core #(
    parameter int ATAN_STEPS = ggh_pkg::ATAN_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_quat_x,
    input  logic signed [15:0] s_quat_y,
    input  logic signed [15:0] s_quat_z,
    input  logic signed [15:0] s_quat_w,
    input  logic signed [15:0] s_pos_x,
    input  logic signed [15:0] s_pos_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [14:0]        m_forward_speed,
    output logic signed [15:0] m_rotation_speed,
    output logic signed [14:0] m_heading,
    output logic signed [14:0] m_bearing
);
    localparam int N = (ATAN_STEPS < ggh_pkg::ANG_MAX) ? ATAN_STEPS : ggh_pkg::ANG_MAX;
    localparam int DEPTH = N + 3;  // front, prerotation, cells, steer

    logic signed [15:0] goal_x_reg, goal_y_reg;
    logic [13:0] window_reg;
    logic [14:0] gain_reg, cruise_reg, spin_reg;

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            goal_x_reg <= -16'sd256;
            goal_y_reg <= -16'sd256;
            window_reg <= 14'd205;
            gain_reg   <= 15'd2560;
            cruise_reg <= 15'd819;
            spin_reg   <= 15'd2048;
        end else if (cfg_we) begin
            case (cfg_index)
                ggh_pkg::REG_GOAL_X: goal_x_reg <= cfg_data;
                ggh_pkg::REG_GOAL_Y: goal_y_reg <= cfg_data;
                ggh_pkg::REG_WINDOW: window_reg <= cfg_data[13:0];
                ggh_pkg::REG_GAIN:   gain_reg   <= cfg_data[14:0];
                ggh_pkg::REG_CRUISE: cruise_reg <= cfg_data[14:0];
                ggh_pkg::REG_SPIN:   spin_reg   <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    logic adv;
    logic [DEPTH-1:0] vld_reg;
    assign adv = !m_valid || m_ready;
    assign s_ready = adv;

    // Front end: quaternion products and position differences
    logic signed [31:0] wz_reg, xy_reg, yy_reg, zz_reg;
    logic signed [16:0] dx_reg, dy_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            wz_reg <= s_quat_w * s_quat_z;
            xy_reg <= s_quat_x * s_quat_y;
            yy_reg <= s_quat_y * s_quat_y;
            zz_reg <= s_quat_z * s_quat_z;
            dx_reg <= 17'(goal_x_reg) - 17'(s_pos_x);
            dy_reg <= 17'(goal_y_reg) - 17'(s_pos_y);
        end
    end

    logic signed [ggh_pkg::CW-1:0] t3, t4, dxs, dys;
    assign t3 = (ggh_pkg::CW'(wz_reg) + ggh_pkg::CW'(xy_reg)) <<< 1;
    assign t4 = (ggh_pkg::CW'(1) <<< 28)
              - ((ggh_pkg::CW'(yy_reg) + ggh_pkg::CW'(zz_reg)) <<< 1);
    assign dxs = ggh_pkg::CW'(dx_reg) <<< 16;
    assign dys = ggh_pkg::CW'(dy_reg) <<< 16;

    logic signed [14:0] head, bear;
    ggh_cordic_chain #(.ATAN_STEPS(ATAN_STEPS)) u_head (
        .aclk(aclk), .en(adv), .y_in(t3), .x_in(t4), .angle(head)
    );
    ggh_cordic_chain #(.ATAN_STEPS(ATAN_STEPS)) u_bear (
        .aclk(aclk), .en(adv), .y_in(dys), .x_in(dxs), .angle(bear)
    );

    // Steer stage: error, multiply, branch decision
    logic signed [15:0] err;
    logic [15:0] aerr;
    assign err  = 16'(head) - 16'(bear);
    assign aerr = err[15] ? 16'(-err) : 16'(err);

    logic signed [31:0] prod_reg;
    logic in_win_reg, pos_reg, neg_reg;
    logic signed [14:0] head_reg, bear_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg   <= 32'($signed({1'b0, gain_reg})) * 32'(err);
            in_win_reg <= aerr < {2'b00, window_reg};
            pos_reg    <= !err[15] && (err != '0);
            neg_reg    <= err[15];
            head_reg   <= head;
            bear_reg   <= bear;
        end
    end

    logic signed [32:0] rr;
    logic signed [24:0] rs;
    logic signed [15:0] rot;
    always_comb begin
        rr = 33'(128) - 33'(prod_reg);
        rs = rr[32:8];
        if (!in_win_reg) begin
            rot = pos_reg ? -16'($signed({1'b0, spin_reg}))
                : (neg_reg ? 16'($signed({1'b0, spin_reg})) : 16'sd0);
        end else if (rs > 25'sd32767) begin
            rot = 16'sd32767;
        end else if (rs < -25'sd32768) begin
            rot = -16'sd32768;
        end else begin
            rot = rs[15:0];
        end
    end

    // Advance valid bits and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            m_valid <= 1'b0;
        end else if (adv) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_valid};
            m_valid <= vld_reg[DEPTH-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_forward_speed  <= in_win_reg ? cruise_reg : 15'd0;
            m_rotation_speed <= rot;
            m_heading        <= head_reg;
            m_bearing        <= bear_reg;
        end
    end

    // A stalled result must hold
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rotation_speed))
        else $error("result changed while stalled");
    // Outside the window no forward drive
    a_fwd: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && vld_reg[DEPTH-1] && !in_win_reg |=> m_forward_speed == '0)
        else $error("forward speed outside window");
    // Heading stays within +/- pi
    a_rng: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_heading <= 15'sd12868) && (m_heading >= -15'sd12868))
        else $error("heading out of range");
endmodule

>>> tb/ggh_checker.sv
// Checker for the go-to-goal heading controller: tracks register writes, predicts
// the command for each pose transaction and compares results. Depends on ggh_pkg.
`timescale 1ns / 1ps
module ggh_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [15:0] s_quat_x,
    input  logic signed [15:0] s_quat_y,
    input  logic signed [15:0] s_quat_z,
    input  logic signed [15:0] s_quat_w,
    input  logic signed [15:0] s_pos_x,
    input  logic signed [15:0] s_pos_y,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [14:0]        m_forward_speed,
    input  logic signed [15:0] m_rotation_speed,
    input  logic signed [14:0] m_heading,
    input  logic signed [14:0] m_bearing,
    output int                 errors,
    output int                 pending,
    output int                 results_seen
);
    typedef struct packed {
        logic [14:0]        fwd;
        logic signed [15:0] rot;
        logic signed [14:0] head;
        logic signed [14:0] bear;
    } command_t;

    command_t cmd_q[$];
    logic signed [15:0] goal_x, goal_y;
    logic [13:0] window;
    logic [14:0] gain, cruise, spin;

    // floor shift on 64-bit signed values
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    // vectoring arctangent, Q3.12 result
    function automatic longint vector_angle(longint y, longint x);
        longint z, xs, ys;
        int n;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? 3294199 : -3294199;
            x = -x;
            y = -y;
        end
        n = (ggh_pkg::ATAN_STEPS_DEF < ggh_pkg::ANG_MAX) ? ggh_pkg::ATAN_STEPS_DEF
                                                         : ggh_pkg::ANG_MAX;
        for (int i = 0; i < n; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y >= 0) begin
                x = x + ys; y = y - xs; z += longint'(ggh_pkg::atan_q20(i));
            end else begin
                x = x - ys; y = y + xs; z -= longint'(ggh_pkg::atan_q20(i));
            end
        end
        z = floor_shift(z + 128, 8);
        if (z > 12868) z = 12868;
        if (z < -12868) z = -12868;
        return z;
    endfunction

    function automatic command_t steer(longint qx, longint qy, longint qz, longint qw,
                                       longint px, longint py);
        command_t c;
        longint t3, t4, dx, dy, hd, br, err, aerr, rot;
        t3 = 2 * (qw * qz + qx * qy);
        t4 = (longint'(1) << 28) - 2 * (qy * qy + qz * qz);
        dx = (longint'(goal_x) - px) * 65536;
        dy = (longint'(goal_y) - py) * 65536;
        hd = vector_angle(t3, t4);
        br = vector_angle(dy, dx);
        err = hd - br;
        aerr = err < 0 ? -err : err;
        if (aerr < longint'(window)) begin
            rot = floor_shift(-(longint'(gain) * err) + 128, 8);
            if (rot > 32767) rot = 32767;
            if (rot < -32768) rot = -32768;
            c.fwd = cruise;
        end else begin
            rot = err > 0 ? -longint'(spin) : (err < 0 ? longint'(spin) : 0);
            c.fwd = '0;
        end
        c.rot = rot[15:0];
        c.head = hd[14:0];
        c.bear = br[14:0];
        return c;
    endfunction

    assign pending = cmd_q.size();

    always @(posedge aclk) begin
        command_t exp_c;
        if (!aresetn) begin
            goal_x <= -16'sd256; goal_y <= -16'sd256;
            window <= 14'd205; gain <= 15'd2560;
            cruise <= 15'd819; spin <= 15'd2048;
            cmd_q.delete();
            errors <= 0;
            results_seen <= 0;
        end else begin
            // compare the result transaction first
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (cmd_q.size() == 0) begin
                    $error("unexpected result transaction");
                    errors <= errors + 1;
                end else begin
                    exp_c = cmd_q.pop_front();
                    if (m_forward_speed !== exp_c.fwd || m_rotation_speed !== exp_c.rot ||
                        m_heading !== exp_c.head || m_bearing !== exp_c.bear)
                        errors <= errors + 1;
                    if (m_forward_speed !== exp_c.fwd)
                        $error("forward_speed exp %0d got %0d", exp_c.fwd, m_forward_speed);
                    if (m_rotation_speed !== exp_c.rot)
                        $error("rotation_speed exp %0d got %0d", exp_c.rot, m_rotation_speed);
                    if (m_heading !== exp_c.head)
                        $error("heading exp %0d got %0d", exp_c.head, m_heading);
                    if (m_bearing !== exp_c.bear)
                        $error("bearing exp %0d got %0d", exp_c.bear, m_bearing);
                end
            end
            // predict the accepted pose transaction
            if (s_valid && s_ready)
                cmd_q.push_back(steer(s_quat_x, s_quat_y, s_quat_z, s_quat_w,
                                      s_pos_x, s_pos_y));
            // track register writes
            if (cfg_we) begin
                case (cfg_index)
                    ggh_pkg::REG_GOAL_X: goal_x <= cfg_data;
                    ggh_pkg::REG_GOAL_Y: goal_y <= cfg_data;
                    ggh_pkg::REG_WINDOW: window <= cfg_data[13:0];
                    ggh_pkg::REG_GAIN:   gain <= cfg_data[14:0];
                    ggh_pkg::REG_CRUISE: cruise <= cfg_data[14:0];
                    ggh_pkg::REG_SPIN:   spin <= cfg_data[14:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

>>> tb/tb_go_to_goal_heading_controller_core.sv
// Testbench top for the go-to-goal heading controller: drives pose and register
// traffic with random gaps. Depends on ggh_pkg, the core and ggh_checker.
`timescale 1ns / 1ps
module tb_go_to_goal_heading_controller_core;
    localparam int LATENCY = 24;
    localparam int WATCHDOG = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_quat_x = '0, s_quat_y = '0, s_quat_z = '0, s_quat_w = '0;
    logic signed [15:0] s_pos_x = '0, s_pos_y = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [14:0] m_forward_speed;
    logic signed [15:0] m_rotation_speed;
    logic signed [14:0] m_heading, m_bearing;
    int errors, pending, results_seen;
    int send_idle = 0, recv_stall = 0;
    int quiet_cycles = 0;
    int poses_sent = 0;
    logic signed [15:0] i_checker_goal_x_shadow = -16'sd256;
    logic signed [15:0] i_checker_goal_y_shadow = -16'sd256;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    go_to_goal_heading_controller_core i_dut (.*);

    ggh_checker i_checker (.*);

    // receiver stall pattern
    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= recv_stall);

    // watchdog on accepted transactions
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("watchdog expired");
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(ggh_pkg::reg_idx_t idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // drop valid, wait for all results, then for the pipeline to drain
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // hold valid after acceptance; drop it only for an idle gap or a drain
    task automatic send_pose(logic signed [15:0] qx, qy, qz, qw, px, py);
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_quat_x <= qx; s_quat_y <= qy; s_quat_z <= qz; s_quat_w <= qw;
        s_pos_x <= px; s_pos_y <= py;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        poses_sent++;
    endtask

    function automatic logic signed [15:0] rand_quat();
        case ($urandom_range(4))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            default: return 16'($urandom_range(32768)) - 16'sd16384;
        endcase
    endfunction

    task automatic random_pose();
        logic signed [15:0] px, py;
        px = 16'($urandom);
        py = 16'($urandom);
        // poses near the goal are common in practice
        if ($urandom_range(3) == 0) begin
            px = i_checker_goal_x_shadow + $signed(16'($urandom_range(64))) - 16'sd32;
            py = i_checker_goal_y_shadow + $signed(16'($urandom_range(64))) - 16'sd32;
        end
        send_pose(rand_quat(), rand_quat(), rand_quat(), rand_quat(), px, py);
    endtask

    task automatic set_goal(logic signed [15:0] gx, gy);
        write_reg(ggh_pkg::REG_GOAL_X, gx);
        write_reg(ggh_pkg::REG_GOAL_Y, gy);
        i_checker_goal_x_shadow = gx;
        i_checker_goal_y_shadow = gy;
    endtask

    initial begin
        int phase;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes and special angles at reset settings
        send_pose(0, 0, 0, 16'sd16384, -16'sd256, -16'sd256);   // zero vector
        send_pose(0, 0, 0, 16'sd16384, 0, -16'sd256);           // goal on -x axis
        send_pose(0, 0, 16'sd16384, 0, 0, 0);                   // yaw pi
        send_pose(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 16'sh7fff, 16'sh8000);
        send_pose(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, 16'sh8000, 16'sh7fff);
        send_pose(16'sd16384, -16'sd16384, 0, 0, 16'sh8000, 16'sh8000);
        send_pose(0, 0, 16'sd11585, 16'sd11585, -16'sd256, -16'sd512);
        drain();

        // extremes of the registers, including zero window with zero error
        write_reg(ggh_pkg::REG_WINDOW, 16'd0);
        write_reg(ggh_pkg::REG_GAIN, 16'h7fff);
        write_reg(ggh_pkg::REG_CRUISE, 16'h7fff);
        write_reg(ggh_pkg::REG_SPIN, 16'hffff);
        write_reg(ggh_pkg::reg_idx_t'(3'd7), 16'h1234);   // out of range, ignored
        set_goal(16'sh7fff, 16'sh7fff);
        send_pose(0, 0, 0, 16'sd16384, 16'sh7fff, 16'sh7fff);
        send_pose(0, 0, 0, 16'sd16384, 0, 16'sh7fff);
        drain();
        write_reg(ggh_pkg::REG_WINDOW, 16'd12868);
        set_goal(16'sh8000, 16'sh8000);
        send_pose(0, 0, 16'sd16384, 16'sd1, 16'sh7fff, 16'sh7fff);
        send_pose(0, 0, -16'sd16384, 16'sd1, 16'sh7fff, 16'sh7fff);
        send_pose(0, 0, 0, 16'sd16384, 16'sh7fff, 16'sh8000);
        drain();

        // random phases with varying settings and idling
        for (phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 83; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 83; end
                default: begin send_idle = 19; recv_stall = 19; end
            endcase
            write_reg(ggh_pkg::REG_WINDOW,
                      (phase == 5) ? 16'd0 : 16'($urandom_range(12868)));
            write_reg(ggh_pkg::REG_GAIN, (phase == 6) ? 16'h7fff : 16'($urandom));
            write_reg(ggh_pkg::REG_CRUISE, 16'($urandom));
            write_reg(ggh_pkg::REG_SPIN, (phase == 7) ? 16'h7fff : 16'($urandom));
            set_goal(16'($urandom), 16'($urandom));
            repeat (100) begin
                random_pose();
                // in phase 3, a hold-off every 50th pose until the pipeline empties
                if (phase == 3 && poses_sent % 50 == 0) begin
                    s_valid <= 1'b0;
                    @(posedge aclk);
                    while (pending != 0) @(posedge aclk);
                end
            end
            drain();
        end

        $display("Covered %0d pose transactions, %0d results, over 8 register settings",
                 poses_sent, results_seen);
        $display("and four idling patterns including zero-window and saturation cases.");
        if (errors == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
